### rtl/rc4sc_pkg.sv
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Types and constants shared by the RC4 stream cipher engine: sequencer
// states, input action codes, configuration register indexes and sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4sc_pkg;

  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned TABLE_AW      = 8;
  localparam int unsigned MAX_KEY_BYTES = 32;
  localparam int unsigned KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int unsigned KEY_WORDS     = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned KEY_LEN_W     = 6;

  // Input action codes.
  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_DATA     = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd4;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd1;

  typedef logic [KEY_WORDS-1:0][7:0][7:0] key_store_t;

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_FILL     = 12'b0000_0000_0010,
    ST_KS_RD_N  = 12'b0000_0000_0100,
    ST_KS_RD_J  = 12'b0000_0000_1000,
    ST_KS_WR_N  = 12'b0000_0001_0000,
    ST_KS_WR_J  = 12'b0000_0010_0000,
    ST_D_RD_I   = 12'b0000_0100_0000,
    ST_D_RD_J   = 12'b0000_1000_0000,
    ST_D_WR_I   = 12'b0001_0000_0000,
    ST_D_WR_J   = 12'b0010_0000_0000,
    ST_D_RD_T   = 12'b0100_0000_0000,
    ST_D_OUT    = 12'b1000_0000_0000
  } state_t;

endpackage : rc4sc_pkg

`default_nettype wire

### rtl/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 engine: key schedule and byte-wise keystream XOR over a single-port
// 256 x 8 permutation memory driven by a small sequencer.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and is stalled while it works.
// A schedule transaction (action 0) fills the table with the identity and
// then runs the 256 swap steps; each step needs two reads and two writes,
// done one at a time, since the sequencer does one table read or one write
// per state. It returns no result and clears both indices. A data
// transaction (action 1) runs three table reads and two writes in sequence,
// then loads the output register. That last step is held for as long as an
// earlier result still waits and the output is stalled. The result goes to
// an output register, so the next transaction can be accepted while a
// result waits.
// The user writes key registers and key length through the cfg port only
// while idle; the block does not enforce this.
// Data must not be sent before the first schedule transaction.
`default_nettype none

module rc4_stream_cipher_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration port
  input  wire logic                             cfg_we,
  input  wire logic [rc4sc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rc4sc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_action,
  input  wire logic [7:0]                       in_data_in,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_data_out
);

  // Configuration registers
  rc4sc_pkg::key_store_t                 key_r;
  logic [rc4sc_pkg::KEY_LEN_W-1:0]       key_len_r;

  // Sequencer and datapath registers
  rc4sc_pkg::state_t                     state_r, state_nxt;
  logic [rc4sc_pkg::TABLE_AW-1:0]        cnt_r, cnt_nxt;
  logic [rc4sc_pkg::KEY_IDX_W-1:0]       kidx_r, kidx_nxt;
  logic [7:0]                            i_r, i_nxt;
  logic [7:0]                            j_r, j_nxt;
  logic [7:0]                            si_r, si_nxt;
  logic [7:0]                            sj_r, sj_nxt;
  logic [7:0]                            din_r, din_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [7:0]                            out_data_r, out_data_nxt;

  // Permutation memory
  logic [7:0]                            perm_mem [rc4sc_pkg::TABLE_DEPTH];
  logic [7:0]                            rd_data_r;
  logic                                  mem_we;
  logic [rc4sc_pkg::TABLE_AW-1:0]        mem_waddr;
  logic [7:0]                            mem_wdata;
  logic                                  mem_re;
  logic [rc4sc_pkg::TABLE_AW-1:0]        mem_raddr;

  logic                                  in_accept;
  logic [rc4sc_pkg::KEY_LEN_W-1:0]       len_eff;
  logic [rc4sc_pkg::KEY_LEN_W-1:0]       len_m1;
  logic [7:0]                            key_byte;
  logic [7:0]                            j_step;

  assign in_stall     = (state_r != rc4sc_pkg::ST_IDLE);
  assign in_accept    = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  // Zero length acts as one byte; lengths above the key store saturate.
  always_comb begin
    if (key_len_r == '0) begin
      len_eff = rc4sc_pkg::KEY_LEN_W'(1);
    end else if (key_len_r > rc4sc_pkg::KEY_LEN_W'(rc4sc_pkg::MAX_KEY_BYTES)) begin
      len_eff = rc4sc_pkg::KEY_LEN_W'(rc4sc_pkg::MAX_KEY_BYTES);
    end else begin
      len_eff = key_len_r;
    end
  end

  assign len_m1   = len_eff - rc4sc_pkg::KEY_LEN_W'(1);
  assign key_byte = key_r[kidx_r[4:3]][kidx_r[2:0]];

  // The one adder that every j index update goes through.
  always_comb begin
    if (state_r == rc4sc_pkg::ST_KS_RD_J) begin
      j_step = j_r + rd_data_r + key_byte;
    end else begin
      j_step = j_r + rd_data_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kidx_nxt      = kidx_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    din_nxt       = din_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = cnt_r;
    mem_re        = 1'b0;
    mem_raddr     = cnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      rc4sc_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_action == rc4sc_pkg::ACT_SCHEDULE) begin
            cnt_nxt   = '0;
            kidx_nxt  = '0;
            j_nxt     = '0;
            state_nxt = rc4sc_pkg::ST_FILL;
          end else begin
            i_nxt     = i_r + 8'd1;
            din_nxt   = in_data_in;
            state_nxt = rc4sc_pkg::ST_D_RD_I;
          end
        end
      end
      rc4sc_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = cnt_r;
        cnt_nxt   = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) begin
          state_nxt = rc4sc_pkg::ST_KS_RD_N;
        end
      end
      rc4sc_pkg::ST_KS_RD_N: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_r;
        state_nxt = rc4sc_pkg::ST_KS_RD_J;
      end
      rc4sc_pkg::ST_KS_RD_J: begin
        si_nxt    = rd_data_r;
        j_nxt     = j_step;
        mem_re    = 1'b1;
        mem_raddr = j_step;
        state_nxt = rc4sc_pkg::ST_KS_WR_N;
      end
      rc4sc_pkg::ST_KS_WR_N: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = rd_data_r;
        state_nxt = rc4sc_pkg::ST_KS_WR_J;
      end
      rc4sc_pkg::ST_KS_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = si_r;
        cnt_nxt   = cnt_r + 8'd1;
        if (kidx_r == len_m1[rc4sc_pkg::KEY_IDX_W-1:0]) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + rc4sc_pkg::KEY_IDX_W'(1);
        end
        if (cnt_r == 8'hFF) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = rc4sc_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4sc_pkg::ST_KS_RD_N;
        end
      end
      rc4sc_pkg::ST_D_RD_I: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
        state_nxt = rc4sc_pkg::ST_D_RD_J;
      end
      rc4sc_pkg::ST_D_RD_J: begin
        si_nxt    = rd_data_r;
        j_nxt     = j_step;
        mem_re    = 1'b1;
        mem_raddr = j_step;
        state_nxt = rc4sc_pkg::ST_D_WR_I;
      end
      rc4sc_pkg::ST_D_WR_I: begin
        sj_nxt    = rd_data_r;
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = rd_data_r;
        state_nxt = rc4sc_pkg::ST_D_WR_J;
      end
      rc4sc_pkg::ST_D_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = si_r;
        state_nxt = rc4sc_pkg::ST_D_RD_T;
      end
      rc4sc_pkg::ST_D_RD_T: begin
        // The swap leaves the pair sum unchanged, so the saved values serve.
        mem_re    = 1'b1;
        mem_raddr = si_r + sj_r;
        state_nxt = rc4sc_pkg::ST_D_OUT;
      end
      rc4sc_pkg::ST_D_OUT: begin
        // Wait here until the output register is free to take the result.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = din_r ^ rd_data_r;
          state_nxt     = rc4sc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rc4sc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= perm_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      key_len_r <= rc4sc_pkg::KEY_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rc4sc_pkg::REG_KEY_0_7:   key_r[0]  <= cfg_wdata;
        rc4sc_pkg::REG_KEY_8_15:  key_r[1]  <= cfg_wdata;
        rc4sc_pkg::REG_KEY_16_23: key_r[2]  <= cfg_wdata;
        rc4sc_pkg::REG_KEY_24_31: key_r[3]  <= cfg_wdata;
        rc4sc_pkg::REG_KEY_LEN:   key_len_r <= cfg_wdata[rc4sc_pkg::KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4sc_pkg::ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    kidx_r     <= kidx_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    din_r      <= din_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule : rc4_stream_cipher_unit

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RC4 stream cipher unit. A cycle-free keystream
// predictor tracks the permutation and both indices. Each accepted byte
// transaction queues the expected ciphertext, and the monitor compares every
// returned byte in order. Keys and lengths are reloaded between phases while
// the unit is idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF       = 4;
  localparam int DRAIN_CYCLES   = 1400;   // longer than one key schedule
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int RANDOM_ITEMS   = 575;
  localparam int MAX_PRINTS     = 100;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } cipher_item_t;

  logic                             clk;
  logic                             rst_n       = 1'b0;
  logic                             cfg_we      = 1'b0;
  logic [rc4sc_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [rc4sc_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                             in_valid    = 1'b0;
  logic                             in_stall;
  logic                             in_action   = rc4sc_pkg::ACT_SCHEDULE;
  logic [7:0]                       in_data_in  = '0;
  logic                             out_valid;
  logic                             out_stall   = 1'b0;
  logic [7:0]                       out_data_out;

  // Predictor state: its own copy of the key registers and the cipher state.
  rc4sc_pkg::key_store_t            tb_key      = '0;
  logic [rc4sc_pkg::KEY_LEN_W-1:0]  tb_key_len  = rc4sc_pkg::KEY_LEN_RESET;
  logic [7:0]                       sbox [rc4sc_pkg::TABLE_DEPTH];
  logic [7:0]                       idx_i       = '0;
  logic [7:0]                       idx_j       = '0;

  cipher_item_t          pending_items [$];
  logic [7:0]            cipher_bytes  [$];

  int                    err_cnt     = 0;
  int                    burst_left  = 0;
  int                    gap_left    = 0;
  int                    stall_mode  = 0;
  int                    stall_run   = 0;
  int                    idle_cycles = 0;
  bit                    took_item;
  logic [7:0]            want_byte;

  rc4_stream_cipher_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Rebuilds the permutation from the current key and clears both indices.
  function automatic void run_key_schedule();
    int         len;
    int         k;
    logic [7:0] j;
    logic [7:0] t;
    len = tb_key_len;
    if (len == 0) len = 1;
    if (len > rc4sc_pkg::MAX_KEY_BYTES) len = rc4sc_pkg::MAX_KEY_BYTES;
    for (int n = 0; n < rc4sc_pkg::TABLE_DEPTH; n++) sbox[n] = 8'(n);
    j = '0;
    for (int n = 0; n < rc4sc_pkg::TABLE_DEPTH; n++) begin
      k = n % len;
      j = j + sbox[n] + tb_key[k >> 3][k & 7];
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  function automatic void predict_cipher(input logic action, input logic [7:0] din);
    logic [7:0] t;
    logic [7:0] ks_idx;
    if (action == rc4sc_pkg::ACT_SCHEDULE) begin
      run_key_schedule();
    end else begin
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + sbox[idx_i];
      t = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      ks_idx = sbox[idx_i] + sbox[idx_j];
      cipher_bytes.push_back(din ^ sbox[ks_idx]);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("MISMATCH at %0t: %s: got %02h, expected %02h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic queue_item(input logic action, input logic [7:0] din);
    cipher_item_t item;
    item.action = action;
    item.data   = din;
    pending_items.push_back(item);
  endtask

  // Waits until every transaction is taken and every byte returned, then lets
  // a possible trailing key schedule finish before anything is reconfigured.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || cipher_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic drive_reg(input logic [rc4sc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4sc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx <= rc4sc_pkg::REG_KEY_24_31) tb_key[idx[1:0]] = val;
    else if (idx == rc4sc_pkg::REG_KEY_LEN) tb_key_len = val[rc4sc_pkg::KEY_LEN_W-1:0];
  endtask

  task automatic load_config(input rc4sc_pkg::key_store_t key,
                             input logic [rc4sc_pkg::KEY_LEN_W-1:0] len,
                             input bit poke_unused);
    logic [rc4sc_pkg::CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[rc4sc_pkg::KEY_LEN_W-1:0] = len;
    for (int w = 0; w < rc4sc_pkg::KEY_WORDS; w++)
      drive_reg(rc4sc_pkg::CFG_IDX_W'(rc4sc_pkg::REG_KEY_0_7 + w), key[w]);
    drive_reg(rc4sc_pkg::REG_KEY_LEN, len_word);
    // Indexes past the register list must be ignored by the unit.
    if (poke_unused)
      for (int r = rc4sc_pkg::REG_KEY_LEN + 1; r < (1 << rc4sc_pkg::CFG_IDX_W); r++)
        drive_reg(rc4sc_pkg::CFG_IDX_W'(r), {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: bursts of back-to-back transactions separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      took_item = in_valid && !in_stall;
      if (took_item) begin
        predict_cipher(in_action, in_data_in);
        void'(pending_items.pop_front());
      end
      if (in_valid && !took_item) begin
        // Payload is held while stalled.
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        in_valid   <= 1'b1;
        in_action  <= pending_items[0].action;
        in_data_in <= pending_items[0].data;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks returned bytes in order and stalls in changing modes.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (cipher_bytes.size() == 0) begin
          report_mismatch("unexpected byte", out_data_out, 8'h00);
        end else begin
          want_byte = cipher_bytes.pop_front();
          if (out_data_out !== want_byte) report_mismatch("data_out", out_data_out, want_byte);
        end
      end
      if (stall_run == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_run  <= $urandom_range(16, 300);
      end else begin
        stall_run <= stall_run - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rc4_stream_cipher_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rc4sc_pkg::key_store_t           key;
    logic [rc4sc_pkg::KEY_LEN_W-1:0] len;
    int                              issued;
    int                              stream_len;
    bit                              first_random;
    issued       = 0;
    first_random = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset key: all-zero bytes, length one.
    queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'hA5);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h00);
    queue_item(rc4sc_pkg::ACT_DATA, 8'hFF);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h55);
    queue_item(rc4sc_pkg::ACT_DATA, 8'hAA);
    wait_idle();

    // Short text key with junk in the unused key bytes; a second schedule
    // in mid-stream must restart the keystream from the top.
    key = '0;
    key[0] = 64'hA5A5_5A5A_0079_654B;
    key[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    load_config(key, 6'd3, 1'b1);
    queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'hFF);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h50);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h6C);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h61);
    queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'h00);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h50);
    queue_item(rc4sc_pkg::ACT_DATA, 8'hFF);
    wait_idle();

    // Full-length key of all ones.
    key = '1;
    load_config(key, 6'(rc4sc_pkg::MAX_KEY_BYTES), 1'b0);
    queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'h3C);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h00);
    queue_item(rc4sc_pkg::ACT_DATA, 8'hFF);
    wait_idle();

    // Zero length behaves as one; lengths above the maximum saturate.
    for (int w = 0; w < rc4sc_pkg::KEY_WORDS; w++) key[w] = {$urandom, $urandom};
    load_config(key, 6'd0, 1'b0);
    queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'h00);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h81);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h7E);
    wait_idle();
    load_config(key, 6'h3F, 1'b0);
    queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'h00);
    queue_item(rc4sc_pkg::ACT_DATA, 8'h01);
    wait_idle();
    load_config(key, 6'(rc4sc_pkg::MAX_KEY_BYTES + 1), 1'b0);
    queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'h80);
    queue_item(rc4sc_pkg::ACT_DATA, 8'hFE);
    wait_idle();

    // Random phases: new key, a schedule, then a byte stream with the odd
    // rekey in it. The first stream is long enough for index i to wrap.
    while (issued < RANDOM_ITEMS) begin
      for (int w = 0; w < rc4sc_pkg::KEY_WORDS; w++) key[w] = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0:       len = 6'd0;
        1:       len = 6'h3F;
        2:       len = 6'(rc4sc_pkg::MAX_KEY_BYTES + 1);
        3:       len = 6'(rc4sc_pkg::MAX_KEY_BYTES);
        4:       len = 6'd1;
        default: len = 6'($urandom_range(1, rc4sc_pkg::MAX_KEY_BYTES));
      endcase
      load_config(key, len, $urandom_range(0, 3) == 0);
      queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'($urandom));
      issued++;
      stream_len = first_random ? 300 : $urandom_range(5, 60);
      first_random = 1'b0;
      repeat (stream_len) begin
        if ($urandom_range(0, 49) == 0) queue_item(rc4sc_pkg::ACT_SCHEDULE, 8'($urandom));
        else queue_item(rc4sc_pkg::ACT_DATA, 8'($urandom));
        issued++;
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("rc4_stream_cipher_unit test passed");
    end else begin
      $display("rc4_stream_cipher_unit test failed");
    end
    $finish;
  end

endmodule
